### rtl/aat_pkg.sv
// Shared types and constants for the aging address table.
`timescale 1ns / 1ps

package aat_pkg;

  localparam int LIFE_W = 16;
  localparam int ADDR_PORT_W = 48;
  localparam int SLOT_W = 3;
  localparam int KIND_W = 2;

  localparam logic [LIFE_W-1:0] LIFE_RESET = 16'd30;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_TICK = 2'd0;
  localparam kind_t KIND_ADD = 2'd1;
  localparam kind_t KIND_LOOKUP = 2'd2;

  typedef logic [LIFE_W-1:0] life_t;

endpackage

### rtl/aging_address_table.sv
// Aging address table: top level with entry memories and walk sequencer.
`timescale 1ns / 1ps
//
// Usage: one item a beat on the input channel (in_valid/in_stall, fields kind
// and address). kind tick ages every live entry by one, add stores the address
// in the first free entry (or the entry closest to expiry) and loads it with
// lifetime_ticks, lookup reports whether a live entry holds the address.
// Every item gives exactly one result beat on the output channel
// (out_valid/out_stall, fields hit and slot_written). The user must write
// lifetime_ticks via cfg_we/cfg_wdata only while the block is idle, unchecked.
//
// Sequencing: each item walks the lifetime and address memories through their
// single read port, one entry a cycle; the input stays busy until the item
// is finished, and an add also passes a commit state that writes the chosen
// entry. One item is in flight at a time. The result sits in an output
// register: the next item is taken while it waits, and a stalled result holds
// until taken; a finished item waits for the register to free up before the
// next one is accepted.
// Reset (rst, synchronous) empties the table through per-entry valid bits,
// restores lifetime_ticks to 30 and drops any pending result.
//
module aging_address_table
  import aat_pkg::*;
#(
  parameter int ENTRIES = 8,
  parameter int ADDRESS_BYTES = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  kind_t                  kind,
  input  logic [ADDR_PORT_W-1:0] address,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   hit,
  output logic [SLOT_W-1:0]      slot_written,
  input  logic                   cfg_we,
  input  logic [LIFE_W-1:0]      cfg_wdata
);

  localparam int AW = (8 * ADDRESS_BYTES < ADDR_PORT_W) ? 8 * ADDRESS_BYTES : ADDR_PORT_W;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] ENTRY_COUNT = CW'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_FINISH} state_t;

  state_t state;
  life_t lifetime_ticks;

  kind_t item_kind;
  logic [AW-1:0] item_addr;

  // Entry storage
  logic [AW-1:0] addr_mem [ENTRIES];
  life_t life_mem [ENTRIES];
  logic [ENTRIES-1:0] ent_vld;

  logic [AW-1:0] addr_q;
  life_t life_q;
  logic val_q;

  // Walk control
  logic [CW-1:0] rd_idx;
  logic rd_go;
  logic pr_vld;
  logic [IW-1:0] pr_idx;
  logic pr_last;
  life_t eff_life;

  // Add slot search and lookup result
  logic found_free;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] best_idx;
  life_t best_life;
  logic [IW-1:0] pick_idx;
  logic res_hit;

  // Write ports
  logic life_we;
  logic [IW-1:0] life_wa;
  life_t life_wd;
  logic addr_we;

  assign in_stall = (state != S_IDLE);
  assign rd_go = (state == S_SCAN) && (rd_idx < ENTRY_COUNT);
  assign pr_last = pr_vld && (pr_idx == LAST_IDX);
  assign eff_life = val_q ? life_q : '0;
  assign pick_idx = found_free ? free_idx : best_idx;

  always_comb begin
    life_we = 1'b0;
    life_wa = pr_idx;
    life_wd = eff_life - life_t'(1);
    addr_we = 1'b0;
    if (state == S_SCAN && pr_vld && item_kind == KIND_TICK && eff_life != '0) begin
      life_we = 1'b1;
    end else if (state == S_COMMIT) begin
      life_we = 1'b1;
      life_wa = pick_idx;
      life_wd = lifetime_ticks;
      addr_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      life_q <= life_mem[rd_idx[IW-1:0]];
      addr_q <= addr_mem[rd_idx[IW-1:0]];
      val_q <= ent_vld[rd_idx[IW-1:0]];
    end
    if (life_we) begin
      life_mem[life_wa] <= life_wd;
    end
    if (addr_we) begin
      addr_mem[pick_idx] <= item_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (addr_we) begin
      ent_vld[pick_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime_ticks <= LIFE_RESET;
    end else if (cfg_we) begin
      lifetime_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pr_vld <= 1'b0;
      rd_idx <= '0;
    end else begin
      pr_vld <= rd_go;
      pr_idx <= rd_idx[IW-1:0];
      if (state == S_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_kind <= kind;
            item_addr <= address[AW-1:0];
            rd_idx <= '0;
            found_free <= 1'b0;
            free_idx <= '0;
            best_idx <= '0;
            best_life <= lifetime_ticks;
            res_hit <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_go) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (pr_vld) begin
            if (item_kind == KIND_ADD) begin
              if (!found_free && eff_life == '0) begin
                found_free <= 1'b1;
                free_idx <= pr_idx;
              end
              if (eff_life < best_life) begin
                best_idx <= pr_idx;
                best_life <= eff_life;
              end
            end
            if (item_kind == KIND_LOOKUP && eff_life != '0 && addr_q == item_addr) begin
              res_hit <= 1'b1;
            end
          end
          if (pr_last) begin
            state <= (item_kind == KIND_ADD) ? S_COMMIT : S_FINISH;
          end
        end
        S_COMMIT: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold the result until the output register is free
          if (!out_valid || !out_stall) begin
            hit <= res_hit;
            slot_written <= (item_kind == KIND_ADD) ? SLOT_W'(pick_idx) : '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/aat_checker.sv
// Port-level checks for the aging address table, bound to the top level.
`timescale 1ns / 1ps

module aat_checker
  import aat_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              hit,
  input logic [SLOT_W-1:0] slot_written
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(slot_written))
    else $error("result changed while stalled");

  // one item at a time: an accepted beat closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accepted beat");

  // a lookup hit never carries a written slot
  a_hit_no_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> slot_written == '0)
    else $error("hit with nonzero slot");

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind aging_address_table aat_checker u_aat_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .hit(hit),
  .slot_written(slot_written)
);

### tb/sv/tb_top.sv
// Self-checking bench for the aging address table: directed table, then random beats.
`timescale 1ns / 1ps

module tb_top;
  import aat_pkg::*;

  localparam int ENTRIES = 8;
  localparam int ADDRESS_BYTES = 6;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int POOL = 12;
  localparam int SETTLE = ENTRIES + 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam logic [ADDR_PORT_W-1:0] ADDR_MASK = (ADDRESS_BYTES >= 6) ?
    {ADDR_PORT_W{1'b1}} : ADDR_PORT_W'((64'd1 << (8 * ADDRESS_BYTES)) - 64'd1);

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } table_result_t;

  typedef struct {
    kind_t                  kind;
    logic [ADDR_PORT_W-1:0] addr;
    bit                     typed;
    logic                   hit;
    logic [SLOT_W-1:0]      slot;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  kind_t                  kind = KIND_TICK;
  logic [ADDR_PORT_W-1:0] address = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   hit;
  logic [SLOT_W-1:0]      slot_written;
  logic                   cfg_we = 1'b0;
  logic [LIFE_W-1:0]      cfg_wdata = '0;

  // shadow copy of the table
  logic [ADDR_PORT_W-1:0] shadow_addr [ENTRIES];
  life_t                  shadow_life [ENTRIES];
  life_t                  shadow_cfg;

  table_result_t          pending_results [$];
  logic [ADDR_PORT_W-1:0] address_pool [POOL];
  plan_row_t              plan [23];
  life_t                  phase_life [PHASES];

  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 72;
  int          cycles = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          lookup_hits = 0;
  int          settings_used = 0;
  int          kind_count [4] = '{0, 0, 0, 0};

  aging_address_table #(
    .ENTRIES(ENTRIES),
    .ADDRESS_BYTES(ADDRESS_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .address(address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .slot_written(slot_written),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [ADDR_PORT_W-1:0] rand_address();
    return {16'($urandom_range(65535)), 32'($urandom)};
  endfunction

  // Apply one item to the shadow table and return the result it gives.
  function automatic table_result_t age_table_step(kind_t k, logic [ADDR_PORT_W-1:0] a);
    table_result_t r;
    int            slot;
    life_t         least;
    r = '0;
    case (k)
      KIND_TICK: begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_life[i] != 0) shadow_life[i] = shadow_life[i] - 1'b1;
      end
      KIND_ADD: begin
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && shadow_life[i] == 0) slot = i;
        if (slot < 0) begin
          // no free entry: first one strictly closest to expiry, else entry 0
          slot = 0;
          least = shadow_cfg;
          for (int i = 0; i < ENTRIES; i++)
            if (shadow_life[i] < least) begin
              slot = i;
              least = shadow_life[i];
            end
        end
        shadow_addr[slot] = a;
        shadow_life[slot] = shadow_cfg;
        r.slot = SLOT_W'(slot);
      end
      KIND_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_life[i] != 0 && shadow_addr[i] == a) r.hit = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Receiver side: random stall, driven at the falling edge.
  always @(negedge clk) out_stall <= !rst && ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("beat with nothing expected: hit=%0b slot=%0d",
                                hit, slot_written));
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit)
          note_mismatch($sformatf("result %0d hit: expected %0b, got %0b",
                                  results_seen, want.hit, hit));
        if (slot_written !== want.slot)
          note_mismatch($sformatf("result %0d slot_written: expected %0d, got %0d",
                                  results_seen, want.slot, slot_written));
        results_seen++;
      end
    end
  end

  // Present one beat, hold it until taken, then log what it should give.
  task automatic send_item(input kind_t k, input logic [ADDR_PORT_W-1:0] a,
                           input bit typed, input table_result_t fixed);
    table_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    address <= a;
    do @(posedge clk); while (in_stall);
    predicted = age_table_step(k, a & ADDR_MASK);
    pending_results.push_back(typed ? fixed : predicted);
    kind_count[k]++;
    if (k == KIND_LOOKUP && predicted.hit) lookup_hits++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_lifetime(input life_t v);
    drain();
    // an add has written its entry before its result beat is given
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_cfg = v;
    settings_used++;
  endtask

  initial begin
    table_result_t          fixed;
    logic [ADDR_PORT_W-1:0] a;
    kind_t                  k;
    int unsigned            roll;

    for (int i = 0; i < ENTRIES; i++) begin
      shadow_addr[i] = '0;
      shadow_life[i] = '0;
    end
    shadow_cfg = LIFE_RESET;
    address_pool[0] = '0;
    address_pool[1] = {ADDR_PORT_W{1'b1}};
    for (int i = 2; i < POOL; i++) address_pool[i] = rand_address();
    phase_life = '{16'd1, 16'd0, 16'hFFFF, LIFE_W'($urandom_range(2, 6)),
                   LIFE_W'($urandom_range(3, 20)), LIFE_W'($urandom_range(100, 65534))};

    // kind, address, typed, hit, slot; reset lifetime of 30 throughout
    plan = '{
      '{KIND_TICK,   48'h0000_0000_0000, 1'b1, 1'b0, 3'd0},
      '{KIND_LOOKUP, 48'h0000_0000_0000, 1'b1, 1'b0, 3'd0},
      '{KIND_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 3'd0},
      '{KIND_ADD,    48'h0000_0000_0000, 1'b1, 1'b0, 3'd0},
      '{KIND_ADD,    48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 3'd1},
      '{KIND_LOOKUP, 48'h0000_0000_0000, 1'b1, 1'b1, 3'd0},
      '{KIND_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 3'd0},
      '{KIND_LOOKUP, 48'hFFFF_FFFF_FFFE, 1'b1, 1'b0, 3'd0},
      '{KIND_UNUSED, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 3'd0},
      '{KIND_ADD,    48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, 3'd2},
      '{KIND_ADD,    48'h5555_5555_5555, 1'b1, 1'b0, 3'd3},
      '{KIND_ADD,    48'h0000_0000_0000, 1'b1, 1'b0, 3'd4},
      '{KIND_ADD,    48'h0000_0000_0001, 1'b1, 1'b0, 3'd5},
      '{KIND_ADD,    48'h8000_0000_0000, 1'b1, 1'b0, 3'd6},
      '{KIND_ADD,    48'h1234_5678_9ABC, 1'b1, 1'b0, 3'd7},
      '{KIND_TICK,   48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 3'd0},
      '{KIND_ADD,    48'hDEAD_BEEF_0042, 1'b1, 1'b0, 3'd0},
      '{KIND_LOOKUP, 48'h0000_0000_0000, 1'b1, 1'b1, 3'd0},
      '{KIND_ADD,    48'h0002_0000_0000, 1'b0, 1'b0, 3'd0},
      '{KIND_LOOKUP, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 3'd0},
      '{KIND_LOOKUP, 48'hDEAD_BEEF_0042, 1'b0, 1'b0, 3'd0},
      '{KIND_UNUSED, 48'h0000_0000_0000, 1'b1, 1'b0, 3'd0},
      '{KIND_LOOKUP, 48'h5555_5555_5554, 1'b0, 1'b0, 3'd0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      fixed.hit = plan[i].hit;
      fixed.slot = plan[i].slot;
      send_item(plan[i].kind, plan[i].addr, plan[i].typed, fixed);
    end

    fixed = '0;
    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        send_idle_pct = 72;
        recv_idle_pct = 24;
      end
      if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_lifetime(phase_life[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        roll = $urandom_range(99);
        if (roll < 30) k = KIND_TICK;
        else if (roll < 62) k = KIND_ADD;
        else if (roll < 95) k = KIND_LOOKUP;
        else k = KIND_UNUSED;
        // mostly reuse a small set of addresses so lookups find them
        roll = $urandom_range(99);
        if (roll < 80) a = address_pool[$urandom_range(POOL - 1)];
        else if (roll < 90)
          a = address_pool[$urandom_range(POOL - 1)] ^
              (ADDR_PORT_W'(1) << $urandom_range(ADDR_PORT_W - 1));
        else a = rand_address();
        send_item(k, a, 1'b0, fixed);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    mismatches += pending_results.size();
    $display("Ran %0d ticks, %0d adds, %0d lookups (%0d hits), %0d unused-kind beats",
             kind_count[KIND_TICK], kind_count[KIND_ADD], kind_count[KIND_LOOKUP],
             lookup_hits, kind_count[KIND_UNUSED]);
    $display("over the reset lifetime and %0d written ones; %0d results checked, %0d bad",
             settings_used, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/aat_pkg.sv
rtl/aging_address_table.sv
rtl/aat_checker.sv
tb/sv/tb_top.sv
